### rtl/msc_pkg.sv
package msc_pkg;

  // Field widths of the words on the three channels.
  localparam int RATE_W       = 20;
  localparam int THRESH_W     = 19;
  localparam int SPEED_W      = 16;
  localparam int TICKS_W      = 16;
  localparam int PERIOD_W     = 10;
  localparam int SCALE_W      = 10;
  localparam int ACCEL_W      = 32;
  localparam int CODE_W       = 2;
  localparam int EVENT_W      = 3;
  localparam int SEG_W        = 2;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 19;

  localparam int COUNT_BITS_DEFAULT = 16;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_CURVE_ENTER    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CURVE_EXIT     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CURVE_CONFIRM  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_STRAIGHT_CONF  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_SPEED      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TELEM_PERIOD   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_DERIV_SCALE    = 3'd6;

  // Register reset values.
  localparam logic [THRESH_W-1:0] RST_CURVE_ENTER   = 19'd3000;
  localparam logic [THRESH_W-1:0] RST_CURVE_EXIT    = 19'd1000;
  localparam logic [TICKS_W-1:0]  RST_CURVE_CONFIRM = 16'd50;
  localparam logic [TICKS_W-1:0]  RST_STRAIGHT_CONF = 16'd100;
  localparam logic [SPEED_W-1:0]  RST_MIN_SPEED     = 16'd100;
  localparam logic [PERIOD_W-1:0] RST_TELEM_PERIOD  = 10'd20;
  localparam logic [SCALE_W-1:0]  RST_DERIV_SCALE   = 10'd50;

  // Input command codes.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_EVENT = 1'b1;

  // Outside event codes.
  localparam logic [CODE_W-1:0] CODE_ACCEL    = 2'd0;
  localparam logic [CODE_W-1:0] CODE_DECEL    = 2'd1;
  localparam logic [CODE_W-1:0] CODE_CURVE    = 2'd2;
  localparam logic [CODE_W-1:0] CODE_STRAIGHT = 2'd3;

  // Result event codes.
  localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
  localparam logic [EVENT_W-1:0] EV_ACCEL    = 3'd1;
  localparam logic [EVENT_W-1:0] EV_DECEL    = 3'd2;
  localparam logic [EVENT_W-1:0] EV_CURVE    = 3'd3;
  localparam logic [EVENT_W-1:0] EV_STRAIGHT = 3'd4;

  // Segment codes.
  localparam logic [SEG_W-1:0] SEG_UNKNOWN  = 2'd0;
  localparam logic [SEG_W-1:0] SEG_STRAIGHT = 2'd1;
  localparam logic [SEG_W-1:0] SEG_CURVE    = 2'd2;

endpackage

### rtl/msc_in_if.sv
interface msc_in_if import msc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic                      moving;
  logic                      rate_fresh;
  logic signed [RATE_W-1:0]  yaw_rate;
  logic [SPEED_W-1:0]        speed_now;
  logic [CODE_W-1:0]         event_code;

  modport source (output valid, command, moving, rate_fresh, yaw_rate, speed_now, event_code,
                  input ready);
  modport sink (input valid, command, moving, rate_fresh, yaw_rate, speed_now, event_code,
                output ready);
endinterface

### rtl/msc_out_if.sv
interface msc_out_if import msc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [EVENT_W-1:0]         event_out;
  logic                       sample_valid;
  logic signed [RATE_W-1:0]   sample_rate;
  logic signed [ACCEL_W-1:0]  angular_accel;
  logic signed [ACCEL_W-1:0]  linear_accel;
  logic [SPEED_W-1:0]         sample_speed;

  modport source (output valid, event_out, sample_valid, sample_rate, angular_accel,
                  linear_accel, sample_speed, input ready);
  modport sink (input valid, event_out, sample_valid, sample_rate, angular_accel,
                linear_accel, sample_speed, output ready);
endinterface

### rtl/msc_cfg_if.sv
interface msc_cfg_if import msc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_ADDR_W-1:0]  addr;
  logic [CFG_DATA_W-1:0]  wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink (input valid, addr, wdata, output ready);
endinterface

### rtl/motion_segment_classifier_unit.sv
// Channel  Dir  Handshake        Word
// in_i     in   valid / ready    command, moving, rate_fresh, yaw_rate, speed_now, event_code
// out_o    out  valid / ready    event_out, sample_valid, sample_rate, angular_accel,
//                                linear_accel, sample_speed
// cfg_i    in   valid / ready    addr (register index), wdata
//
// Every input word yields exactly one result word. A word taken on in_i waits in the
// input register and then moves into the result register, from which out_o offers it.
// One word per cycle is sustained while out_o does not stall: the input register feeds one
// pass of logic (a 21x11 multiply followed by the smoothing add) into the result register.
// Reset (rst_ni low, asynchronous) restores the register defaults and clears all state.
// A stalled out_o holds its word; the input register then keeps one more word and
// in_i ready drops until the result register drains. cfg_i is always ready.
module motion_segment_classifier_unit import msc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  msc_in_if.sink     in_i,
  msc_cfg_if.sink    cfg_i,
  msc_out_if.source  out_o
);

  // Counters compare against the 16-bit confirm values at the wider of both widths.
  localparam int CmpW = (COUNT_BITS > TICKS_W) ? COUNT_BITS : TICKS_W;
  localparam int DiffRW = RATE_W + 1;
  localparam int DiffSW = SPEED_W + 1;
  localparam int SumW = ACCEL_W + 3;
  localparam int QuotW = SumW - 2;

  // Configuration registers.
  logic [THRESH_W-1:0] enter_rate_q, exit_rate_q;
  logic [TICKS_W-1:0]  curve_conf_q, straight_conf_q;
  logic [SPEED_W-1:0]  min_speed_q;
  logic [PERIOD_W-1:0] period_q;
  logic [SCALE_W-1:0]  scale_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enter_rate_q    <= RST_CURVE_ENTER;
      exit_rate_q     <= RST_CURVE_EXIT;
      curve_conf_q    <= RST_CURVE_CONFIRM;
      straight_conf_q <= RST_STRAIGHT_CONF;
      min_speed_q     <= RST_MIN_SPEED;
      period_q        <= RST_TELEM_PERIOD;
      scale_q         <= RST_DERIV_SCALE;
    end else if (cfg_i.valid) begin
      case (cfg_i.addr)
        REG_CURVE_ENTER:   enter_rate_q    <= cfg_i.wdata[THRESH_W-1:0];
        REG_CURVE_EXIT:    exit_rate_q     <= cfg_i.wdata[THRESH_W-1:0];
        REG_CURVE_CONFIRM: curve_conf_q    <= cfg_i.wdata[TICKS_W-1:0];
        REG_STRAIGHT_CONF: straight_conf_q <= cfg_i.wdata[TICKS_W-1:0];
        REG_MIN_SPEED:     min_speed_q     <= cfg_i.wdata[SPEED_W-1:0];
        REG_TELEM_PERIOD:  period_q        <= cfg_i.wdata[PERIOD_W-1:0];
        REG_DERIV_SCALE:   scale_q         <= cfg_i.wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register and handshake. A word moves on when the result register is
  // empty or is being emptied in this cycle.
  logic                     in_vld_q;
  logic                     cmd_q, moving_q, fresh_q;
  logic signed [RATE_W-1:0] rate_q;
  logic [SPEED_W-1:0]       speed_q;
  logic [CODE_W-1:0]        code_q;
  logic                     out_vld_q;
  logic                     advance;

  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q    <= in_i.command;
      moving_q <= in_i.moving;
      fresh_q  <= in_i.rate_fresh;
      rate_q   <= in_i.yaw_rate;
      speed_q  <= in_i.speed_now;
      code_q   <= in_i.event_code;
    end
  end

  // Classifier and telemetry state.
  logic [SEG_W-1:0]           seg_q, seg_d;
  logic [COUNT_BITS-1:0]      curve_cnt_q, curve_cnt_d;
  logic [COUNT_BITS-1:0]      straight_cnt_q, straight_cnt_d;
  logic [PERIOD_W-1:0]        per_cnt_q, per_cnt_d;
  logic signed [RATE_W-1:0]   last_rate_q, last_rate_d;
  logic [SPEED_W-1:0]         last_speed_q, last_speed_d;
  logic signed [ACCEL_W-1:0]  smooth_ang_q, smooth_ang_d;
  logic signed [ACCEL_W-1:0]  smooth_lin_q, smooth_lin_d;

  // Result word under construction.
  logic [EVENT_W-1:0]         ev_d;
  logic                       smp_d;
  logic signed [RATE_W-1:0]   smp_rate_d;
  logic signed [ACCEL_W-1:0]  ang_d, lin_d;
  logic [SPEED_W-1:0]         smp_speed_d;

  // (3 * acc + raw) / 4, rounded toward zero, clamped to the 32-bit range.
  function automatic logic signed [ACCEL_W-1:0] smooth_step(
    input logic signed [ACCEL_W-1:0] acc,
    input logic signed [ACCEL_W-1:0] raw
  );
    logic signed [SumW-1:0]  sum;
    logic signed [QuotW-1:0] quo;
    sum = (SumW'(acc) <<< 1) + SumW'(acc) + SumW'(raw);
    quo = sum[SumW-1:2];
    if (sum[SumW-1] && (sum[1:0] != 2'b00)) begin
      quo = quo + QuotW'(1);
    end
    if (quo[QuotW-1] != quo[ACCEL_W-1]) begin
      smooth_step = quo[QuotW-1] ? {1'b1, {(ACCEL_W-1){1'b0}}} : {1'b0, {(ACCEL_W-1){1'b1}}};
    end else begin
      smooth_step = quo[ACCEL_W-1:0];
    end
  endfunction

  logic [RATE_W-1:0]          mag;
  logic                       gated;
  logic                       curve_inc, straight_inc;
  logic [PERIOD_W-1:0]        per_next;
  logic signed [DiffRW-1:0]   diff_rate;
  logic signed [DiffSW-1:0]   diff_speed;
  logic signed [SCALE_W:0]    scale_s;
  logic signed [ACCEL_W-1:0]  raw_ang, raw_lin;

  // Magnitude of the yaw rate; the most negative input yields 2^19, which still fits.
  assign mag = rate_q[RATE_W-1] ? (~rate_q + RATE_W'(1)) : rate_q;
  assign gated = !moving_q || !fresh_q || (speed_q < min_speed_q);

  // Counters saturate at their confirm value and at their own all-ones value.
  assign curve_inc = (CmpW'(curve_cnt_q) < CmpW'(curve_conf_q)) && !(&curve_cnt_q);
  assign straight_inc = (CmpW'(straight_cnt_q) < CmpW'(straight_conf_q)) &&
                        !(&straight_cnt_q);

  assign per_next   = per_cnt_q + PERIOD_W'(1);
  assign diff_rate  = DiffRW'(rate_q) - DiffRW'(last_rate_q);
  assign diff_speed = $signed({1'b0, speed_q}) - $signed({1'b0, last_speed_q});
  assign scale_s    = $signed({1'b0, scale_q});
  // Both operands are sign-extended first so the product keeps all of its bits.
  assign raw_ang    = ACCEL_W'(diff_rate) * ACCEL_W'(scale_s);
  assign raw_lin    = ACCEL_W'(diff_speed) * ACCEL_W'(scale_s);

  always_comb begin
    seg_d          = seg_q;
    curve_cnt_d    = curve_cnt_q;
    straight_cnt_d = straight_cnt_q;
    per_cnt_d      = per_cnt_q;
    last_rate_d    = last_rate_q;
    last_speed_d   = last_speed_q;
    smooth_ang_d   = smooth_ang_q;
    smooth_lin_d   = smooth_lin_q;
    ev_d           = EV_NONE;
    smp_d          = 1'b0;
    smp_rate_d     = '0;
    ang_d          = '0;
    lin_d          = '0;
    smp_speed_d    = '0;

    if (cmd_q == CMD_EVENT) begin
      // Outside events are echoed; curve and straight also force the segment.
      ev_d = {1'b0, code_q} + EVENT_W'(1);
      if (code_q == CODE_CURVE) begin
        seg_d          = SEG_CURVE;
        curve_cnt_d    = '0;
        straight_cnt_d = '0;
      end else if (code_q == CODE_STRAIGHT) begin
        seg_d          = SEG_STRAIGHT;
        curve_cnt_d    = '0;
        straight_cnt_d = '0;
      end
    end else begin
      // Hysteresis detection: the band between the thresholds clears both counters.
      if (gated) begin
        curve_cnt_d    = '0;
        straight_cnt_d = '0;
      end else if (mag >= RATE_W'(enter_rate_q)) begin
        straight_cnt_d = '0;
        curve_cnt_d    = curve_inc ? curve_cnt_q + COUNT_BITS'(1) : curve_cnt_q;
        if ((CmpW'(curve_cnt_d) >= CmpW'(curve_conf_q)) && (seg_q != SEG_CURVE)) begin
          seg_d          = SEG_CURVE;
          curve_cnt_d    = '0;
          straight_cnt_d = '0;
          ev_d           = EV_CURVE;
        end
      end else if (mag <= RATE_W'(exit_rate_q)) begin
        curve_cnt_d    = '0;
        straight_cnt_d = straight_inc ? straight_cnt_q + COUNT_BITS'(1) : straight_cnt_q;
        if ((CmpW'(straight_cnt_d) >= CmpW'(straight_conf_q)) &&
            (seg_q != SEG_STRAIGHT)) begin
          seg_d          = SEG_STRAIGHT;
          curve_cnt_d    = '0;
          straight_cnt_d = '0;
          ev_d           = EV_STRAIGHT;
        end
      end else begin
        curve_cnt_d    = '0;
        straight_cnt_d = '0;
      end

      // Telemetry runs on every tick, gated or not.
      per_cnt_d = per_next;
      if (per_next >= period_q) begin
        per_cnt_d    = '0;
        last_rate_d  = rate_q;
        last_speed_d = speed_q;
        smooth_ang_d = smooth_step(smooth_ang_q, raw_ang);
        smooth_lin_d = smooth_step(smooth_lin_q, raw_lin);
        smp_d        = 1'b1;
        smp_rate_d   = rate_q;
        ang_d        = smooth_ang_d;
        lin_d        = smooth_lin_d;
        smp_speed_d  = speed_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q          <= SEG_UNKNOWN;
      curve_cnt_q    <= '0;
      straight_cnt_q <= '0;
      per_cnt_q      <= '0;
      last_rate_q    <= '0;
      last_speed_q   <= '0;
      smooth_ang_q   <= '0;
      smooth_lin_q   <= '0;
    end else if (advance) begin
      seg_q          <= seg_d;
      curve_cnt_q    <= curve_cnt_d;
      straight_cnt_q <= straight_cnt_d;
      per_cnt_q      <= per_cnt_d;
      last_rate_q    <= last_rate_d;
      last_speed_q   <= last_speed_d;
      smooth_ang_q   <= smooth_ang_d;
      smooth_lin_q   <= smooth_lin_d;
    end
  end

  // Result register.
  logic [EVENT_W-1:0]         ev_q;
  logic                       smp_q;
  logic signed [RATE_W-1:0]   smp_rate_q;
  logic signed [ACCEL_W-1:0]  ang_q, lin_q;
  logic [SPEED_W-1:0]         smp_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ev_q        <= ev_d;
      smp_q       <= smp_d;
      smp_rate_q  <= smp_rate_d;
      ang_q       <= ang_d;
      lin_q       <= lin_d;
      smp_speed_q <= smp_speed_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.event_out     = ev_q;
  assign out_o.sample_valid  = smp_q;
  assign out_o.sample_rate   = smp_rate_q;
  assign out_o.angular_accel = ang_q;
  assign out_o.linear_accel  = lin_q;
  assign out_o.sample_speed  = smp_speed_q;

endmodule

### dv/tb_motion_segment_classifier_unit.sv
`timescale 1ns / 100ps

module tb_motion_segment_classifier_unit;
  import msc_pkg::*;

  // The block is run with its default counter width, as it is used.
  localparam int COUNT_BITS = COUNT_BITS_DEFAULT;
  localparam longint CNT_MAX = (longint'(1) << COUNT_BITS) - 1;

  // Cycles in which no word moves on any channel before the run is called hung.
  // The limit lies far above the longest sender gap and the longest receiver stall.
  localparam int unsigned QUIET_LIMIT = 1000;

  // Words on the random part of the run, split over configuration phases.
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned WORDS_PER_PHASE = 105;

  typedef struct packed {
    logic                     command;
    logic                     moving;
    logic                     rate_fresh;
    logic signed [RATE_W-1:0] yaw_rate;
    logic [SPEED_W-1:0]       speed_now;
    logic [CODE_W-1:0]        event_code;
  } in_word_t;

  localparam int IN_W = $bits(in_word_t);

  typedef struct packed {
    logic [EVENT_W-1:0]        event_out;
    logic                      sample_valid;
    logic signed [RATE_W-1:0]  sample_rate;
    logic signed [ACCEL_W-1:0] angular_accel;
    logic signed [ACCEL_W-1:0] linear_accel;
    logic [SPEED_W-1:0]        sample_speed;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  msc_in_if  in_if ();
  msc_cfg_if cfg_if ();
  msc_out_if out_if ();

  motion_segment_classifier_unit #(
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the configuration registers, updated when a write is taken.
  logic [THRESH_W-1:0] cfg_enter         = RST_CURVE_ENTER;
  logic [THRESH_W-1:0] cfg_exit          = RST_CURVE_EXIT;
  logic [TICKS_W-1:0]  cfg_curve_conf    = RST_CURVE_CONFIRM;
  logic [TICKS_W-1:0]  cfg_straight_conf = RST_STRAIGHT_CONF;
  logic [SPEED_W-1:0]  cfg_min_speed     = RST_MIN_SPEED;
  logic [PERIOD_W-1:0] cfg_period        = RST_TELEM_PERIOD;
  logic [SCALE_W-1:0]  cfg_scale         = RST_DERIV_SCALE;

  // Shadow copy of the classifier and telemetry state.
  logic [SEG_W-1:0]    seg_state    = SEG_UNKNOWN;
  longint              curve_cnt    = 0;
  longint              straight_cnt = 0;
  logic [PERIOD_W-1:0] period_cnt   = '0;
  int                  last_rate    = 0;
  logic [SPEED_W-1:0]  last_speed   = '0;
  int                  smooth_ang   = 0;
  int                  smooth_lin   = 0;

  // Results predicted for accepted input words, oldest first.
  result_t expected_q[$];

  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned samples_seen = 0;
  int unsigned events_seen[5];
  int unsigned quiet_cycles = 0;
  // When set, the sender puts no gaps between words.
  bit          steady = 1'b0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Entering a segment, by detection or by an outside event, clears both
  // confirm counters.
  function automatic void enter_segment(logic [SEG_W-1:0] seg);
    seg_state    = seg;
    curve_cnt    = 0;
    straight_cnt = 0;
  endfunction

  // Counters stop at the confirm value or at the counter width, whichever is lower.
  function automatic longint count_up(longint c, longint lim);
    if (c < lim && c < CNT_MAX) begin
      return c + 1;
    end
    return c;
  endfunction

  // (3 * acc + raw) / 4 with the division truncating toward zero, clamped to int32.
  function automatic int smooth_next(int acc, longint raw);
    longint v;
    v = (longint'(acc) * 3 + raw) / 4;
    if (v > longint'(32'sh7FFF_FFFF)) begin
      v = longint'(32'sh7FFF_FFFF);
    end
    if (v < -longint'(32'sh7FFF_FFFF) - 1) begin
      v = -longint'(32'sh7FFF_FFFF) - 1;
    end
    return int'(v);
  endfunction

  function automatic result_t predict_result(in_word_t w);
    result_t r;
    int      rate_i;
    longint  mag;
    longint  raw_a;
    longint  raw_l;
    r = '0;
    // An outside event is only echoed; the tick fields do not matter.
    if (w.command == CMD_EVENT) begin
      case (w.event_code)
        CODE_ACCEL: r.event_out = EV_ACCEL;
        CODE_DECEL: r.event_out = EV_DECEL;
        CODE_CURVE: begin
          r.event_out = EV_CURVE;
          enter_segment(SEG_CURVE);
        end
        default: begin
          r.event_out = EV_STRAIGHT;
          enter_segment(SEG_STRAIGHT);
        end
      endcase
      return r;
    end

    rate_i = w.yaw_rate;
    mag = (rate_i < 0) ? -longint'(rate_i) : longint'(rate_i);
    r.event_out = EV_NONE;

    // Detection with hysteresis: the band between the two thresholds clears
    // both counters, as does any gating condition.
    if (!w.moving || !w.rate_fresh || w.speed_now < cfg_min_speed) begin
      curve_cnt    = 0;
      straight_cnt = 0;
    end else if (mag >= longint'(cfg_enter)) begin
      straight_cnt = 0;
      curve_cnt = count_up(curve_cnt, longint'(cfg_curve_conf));
      if (curve_cnt >= longint'(cfg_curve_conf) && seg_state != SEG_CURVE) begin
        enter_segment(SEG_CURVE);
        r.event_out = EV_CURVE;
      end
    end else if (mag <= longint'(cfg_exit)) begin
      curve_cnt = 0;
      straight_cnt = count_up(straight_cnt, longint'(cfg_straight_conf));
      if (straight_cnt >= longint'(cfg_straight_conf) && seg_state != SEG_STRAIGHT) begin
        enter_segment(SEG_STRAIGHT);
        r.event_out = EV_STRAIGHT;
      end
    end else begin
      curve_cnt    = 0;
      straight_cnt = 0;
    end

    // Telemetry runs on every tick, gated or not. The period counter wraps
    // at its own width.
    period_cnt = period_cnt + 1'b1;
    if (period_cnt >= cfg_period) begin
      raw_a = (longint'(rate_i) - longint'(last_rate)) * longint'(cfg_scale);
      raw_l = (longint'(w.speed_now) - longint'(last_speed)) * longint'(cfg_scale);
      period_cnt = '0;
      last_rate  = rate_i;
      last_speed = w.speed_now;
      smooth_ang = smooth_next(smooth_ang, raw_a);
      smooth_lin = smooth_next(smooth_lin, raw_l);
      r.sample_valid  = 1'b1;
      r.sample_rate   = w.yaw_rate;
      r.angular_accel = smooth_ang;
      r.linear_accel  = smooth_lin;
      r.sample_speed  = w.speed_now;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sender gap: mostly none or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned pick;
    if (steady) begin
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      return 0;
    end
    if (pick < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // A tick word. The event code is ignored on ticks, so it is left random.
  function automatic in_word_t tick_word(bit mov, bit fresh, int rate, int speed);
    in_word_t w;
    w.command    = CMD_TICK;
    w.moving     = mov;
    w.rate_fresh = fresh;
    w.yaw_rate   = rate[RATE_W-1:0];
    w.speed_now  = speed[SPEED_W-1:0];
    w.event_code = CODE_W'($urandom);
    return w;
  endfunction

  // An outside event word; all tick fields carry random junk.
  function automatic in_word_t event_word(logic [CODE_W-1:0] code);
    in_word_t w;
    w = IN_W'({$urandom, $urandom});
    w.yaw_rate   = RATE_W'($urandom);
    w.speed_now  = SPEED_W'($urandom);
    w.command    = CMD_EVENT;
    w.event_code = code;
    return w;
  endfunction

  // Sends one word after a random gap and records its predicted result at the
  // edge where it is taken. valid is left high so that a word that follows
  // with no gap goes out back to back.
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= w.command;
    in_if.moving     <= w.moving;
    in_if.rate_fresh <= w.rate_fresh;
    in_if.yaw_rate   <= w.yaw_rate;
    in_if.speed_now  <= w.speed_now;
    in_if.event_code <= w.event_code;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_q.push_back(predict_result(w));
    words_sent++;
  endtask

  // Stops sending and waits until every predicted result has come back, plus
  // a few cycles to cover the two-stage pipeline.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes one register. Bits above the register's width carry random junk,
  // which the block is meant to drop.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned value);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    case (idx)
      REG_CURVE_ENTER, REG_CURVE_EXIT: data = value[CFG_DATA_W-1:0];
      REG_CURVE_CONFIRM, REG_STRAIGHT_CONF, REG_MIN_SPEED: data[15:0] = value[15:0];
      default: data[9:0] = value[9:0];
    endcase
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.wdata <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_CURVE_ENTER:   cfg_enter         = data[THRESH_W-1:0];
      REG_CURVE_EXIT:    cfg_exit          = data[THRESH_W-1:0];
      REG_CURVE_CONFIRM: cfg_curve_conf    = data[TICKS_W-1:0];
      REG_STRAIGHT_CONF: cfg_straight_conf = data[TICKS_W-1:0];
      REG_MIN_SPEED:     cfg_min_speed     = data[SPEED_W-1:0];
      REG_TELEM_PERIOD:  cfg_period        = data[PERIOD_W-1:0];
      REG_DERIV_SCALE:   cfg_scale         = data[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // Drains the block and then writes all seven registers back to back.
  task automatic configure(input int unsigned enter, input int unsigned ext,
                           input int unsigned cconf, input int unsigned sconf,
                           input int unsigned min_sp, input int unsigned period,
                           input int unsigned scale);
    drain();
    write_reg(REG_CURVE_ENTER, enter);
    write_reg(REG_CURVE_EXIT, ext);
    write_reg(REG_CURVE_CONFIRM, cconf);
    write_reg(REG_STRAIGHT_CONF, sconf);
    write_reg(REG_MIN_SPEED, min_sp);
    write_reg(REG_TELEM_PERIOD, period);
    write_reg(REG_DERIV_SCALE, scale);
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every outside event code with the reset configuration, then a plain tick.
  task automatic test_outside_events();
    send_word(event_word(CODE_ACCEL));
    send_word(event_word(CODE_DECEL));
    send_word(event_word(CODE_CURVE));
    send_word(event_word(CODE_STRAIGHT));
    send_word(tick_word(1'b1, 1'b1, 0, 200));
  endtask

  // Zero confirm ticks raise the event on the first qualifying tick, and a zero
  // telemetry period samples every tick, so event and sample share one word.
  // Field extremes and the moving and fresh gates are covered here.
  task automatic test_immediate_confirm();
    configure(3000, 1000, 0, 0, 0, 0, 1000);
    send_word(tick_word(1'b1, 1'b1, -524288, 65535));
    send_word(tick_word(1'b1, 1'b1, 524287, 0));
    send_word(tick_word(1'b1, 1'b1, 0, 65535));
    send_word(tick_word(1'b0, 1'b1, -524288, 100));
    send_word(tick_word(1'b1, 1'b0, -524288, 100));
    send_word(event_word(CODE_CURVE));
    send_word(tick_word(1'b1, 1'b1, 0, 0));
  endtask

  // Thresholds at their exact values, the band between them, confirm counts
  // that need several ticks, and a speed one below the gate.
  task automatic test_hysteresis_band();
    configure(2000, 1000, 3, 2, 500, 4, 7);
    send_word(tick_word(1'b1, 1'b1, 1500, 600));
    send_word(tick_word(1'b1, 1'b1, -1500, 600));
    send_word(tick_word(1'b1, 1'b1, 2000, 700));
    send_word(tick_word(1'b1, 1'b1, -2000, 800));
    send_word(tick_word(1'b1, 1'b1, 2000, 900));
    send_word(tick_word(1'b1, 1'b1, 1000, 900));
    send_word(tick_word(1'b1, 1'b1, -1000, 500));
    send_word(tick_word(1'b1, 1'b1, 2000, 499));
    send_word(tick_word(1'b1, 1'b1, 1001, 500));
    send_word(tick_word(1'b1, 1'b1, -1999, 500));
  endtask

  // Random words for one phase. Most are runs of ticks held at one side of the
  // hysteresis band for about as long as confirmation needs, so segments change
  // often; the rest are band ticks, gated ticks, outside events and junk.
  task automatic run_random_words(input int unsigned n_words);
    int unsigned sent;
    int unsigned kind;
    int unsigned run_len;
    int unsigned target;
    int unsigned pick;
    int          mag;
    int          rate;
    int          speed;
    bit          mov;
    bit          fresh;
    in_word_t    w;
    sent = 0;
    while (sent < n_words) begin
      kind = $urandom_range(0, 99);
      if (kind >= 80) begin
        // Junk: every field random.
        w = IN_W'({$urandom, $urandom});
        w.yaw_rate  = RATE_W'($urandom);
        w.speed_now = SPEED_W'($urandom);
        send_word(w);
        sent++;
      end else begin
        target = (kind < 34) ? 32'(cfg_curve_conf) : 32'(cfg_straight_conf);
        if (target > 120) begin
          target = 120;
        end
        run_len = $urandom_range(1, target + 3);
        for (int unsigned i = 0; i < run_len && sent < n_words; i++) begin
          if (kind < 34) begin
            mag = $urandom_range(524287, cfg_enter);
          end else if (kind < 67) begin
            mag = $urandom_range(cfg_exit, 0);
          end else if (cfg_enter > cfg_exit + 1) begin
            mag = $urandom_range(cfg_enter - 1, cfg_exit + 1);
          end else begin
            mag = $urandom_range(524287, 0);
          end
          rate = $urandom_range(0, 1) ? -mag : mag;
          if (kind < 34 && $urandom_range(0, 19) == 0) begin
            rate = -524288;
          end
          speed = $urandom_range(65535, cfg_min_speed);
          mov   = 1'b1;
          fresh = 1'b1;
          pick  = $urandom_range(0, 99);
          if (pick < 3) begin
            send_word(event_word(CODE_W'($urandom)));
          end else begin
            if (pick < 6) begin
              mov = 1'b0;
            end else if (pick < 9) begin
              fresh = 1'b0;
            end else if (pick < 12 && cfg_min_speed != 0) begin
              speed = $urandom_range(cfg_min_speed - 1, 0);
            end
            send_word(tick_word(mov, fresh, rate, speed));
          end
          sent++;
        end
      end
    end
  endtask

  // One configuration per phase: all lows, all highs, the reset values, and
  // small random settings in between. Every third phase sends with no gaps.
  task automatic test_random_phases();
    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      steady = (p % 3 == 2);
      case (p)
        0: configure(0, 0, 0, 0, 0, 1, 1);
        1: configure(524287, 524287, 65535, 65535, 65535, 1000, 1000);
        2: configure(RST_CURVE_ENTER, RST_CURVE_EXIT, RST_CURVE_CONFIRM, RST_STRAIGHT_CONF,
                     RST_MIN_SPEED, RST_TELEM_PERIOD, RST_DERIV_SCALE);
        default: configure($urandom_range(500, 6000), $urandom_range(0, 2500),
                           $urandom_range(0, 8), $urandom_range(0, 8),
                           $urandom_range(0, 300), $urandom_range(0, 8),
                           $urandom_range(0, 2) == 0 ? 1000 : $urandom_range(1, 1000));
      endcase
      run_random_words(WORDS_PER_PHASE);
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // The receiver holds ready high for a while and then stalls; stalls are
  // mostly short, and now and then a long stretch passes with no stall.
  initial begin
    int unsigned hold;
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      hold  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
      stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      out_if.ready <= 1'b1;
      repeat (hold) @(posedge clk_i);
      out_if.ready <= 1'b0;
      repeat (stall) @(posedge clk_i);
    end
  end

  task automatic check_field(input string name, input logic signed [63:0] exp_v,
                             input logic signed [63:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // Each result word taken is compared with the oldest prediction.
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result word with no prediction waiting, event_out %0d",
                 $time, out_if.event_out);
        mismatches++;
      end else begin
        exp_r = expected_q.pop_front();
        check_field("event_out", exp_r.event_out, out_if.event_out);
        check_field("sample_valid", exp_r.sample_valid, out_if.sample_valid);
        check_field("sample_rate", exp_r.sample_rate, out_if.sample_rate);
        check_field("angular_accel", exp_r.angular_accel, out_if.angular_accel);
        check_field("linear_accel", exp_r.linear_accel, out_if.linear_accel);
        check_field("sample_speed", exp_r.sample_speed, out_if.sample_speed);
        if (exp_r.sample_valid) begin
          samples_seen++;
        end
        events_seen[exp_r.event_out]++;
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, expected_q.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Every input is known from time zero; reset is held low first.
    in_if.valid      <= 1'b0;
    in_if.command    <= CMD_TICK;
    in_if.moving     <= 1'b0;
    in_if.rate_fresh <= 1'b0;
    in_if.yaw_rate   <= '0;
    in_if.speed_now  <= '0;
    in_if.event_code <= CODE_ACCEL;
    cfg_if.valid     <= 1'b0;
    cfg_if.addr      <= REG_CURVE_ENTER;
    cfg_if.wdata     <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_outside_events();
    test_immediate_confirm();
    test_hysteresis_band();
    test_random_phases();
    drain();

    $display("Sent %0d words over %0d configurations; %0d telemetry samples checked.",
             words_sent, RAND_PHASES + 3, samples_seen);
    $display("Events checked: accel %0d, decel %0d, curve %0d, straight %0d.",
             events_seen[EV_ACCEL], events_seen[EV_DECEL], events_seen[EV_CURVE],
             events_seen[EV_STRAIGHT]);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
